/* src/dpg_pkg.sv */
// ----------------------------------------------------------------------------
// dpg_pkg: shared types and constants of the dithered PWM generator
// Register indexes, word widths and the status and configuration bundles
// that pass between the generator's modules.
// ----------------------------------------------------------------------------
package dpg_pkg;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PERIOD        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_DUTY     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_DUTY    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DITHER_LENGTH = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW    = 3'd5;

	// Reset values of the registers.
	localparam logic [15:0] PRESCALE_RST      = 16'd1;
	localparam logic [15:0] PERIOD_RST        = 16'hFFFF;
	localparam logic [15:0] DITHER_LENGTH_RST = 16'd1;

	// Field widths.
	localparam int DUTY_W    = 16;
	localparam int COMPARE_W = 17;

	// Stream word widths.
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	// Dither settings handed to the compare loader.
	typedef struct packed {
		logic [DUTY_W-1:0] base_duty;
		logic [DUTY_W-1:0] extra_duty;
		logic [DUTY_W-1:0] dither_length;
	} dither_cfg_t;

	// Status coming back from the compare loader.
	typedef struct packed {
		logic                 busy;
		logic [COMPARE_W-1:0] compare_next;
	} dither_stat_t;

endpackage

/* src/dithered_pwm_generator.sv */
// ----------------------------------------------------------------------------
// dithered_pwm_generator: PWM timer with a sigma-delta dithered compare
// Each input word is one tick; the block answers every tick with one word
// giving the pin level, a period-start flag and the compare in use. It
// takes one word per clock and holds up to two finished words, so the
// input keeps flowing while the output is briefly stalled. The one
// exception: when dither_length is lowered so far that accumulator plus
// fraction reach twice the length, the next period start occupies the
// remainder unit, and s_tready stays low while it is busy.
// ----------------------------------------------------------------------------
module dithered_pwm_generator #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [dpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dpg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// Input stream; tdata: [0] run, [7:1] zero.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dpg_pkg::IN_DATA_W-1:0]      s_tdata,
	// Output stream; tdata: [0] pwm_level, [1] period_start,
	// [18:2] compare_in_use, [23:19] zero.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dpg_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import dpg_pkg::*;

	localparam int LVL_W = (COUNT_WIDTH > COMPARE_W) ? COUNT_WIDTH : COMPARE_W;

	logic [15:0]            prescale_q;
	logic [15:0]            period_q;
	dither_cfg_t            dither_cfg_q;
	logic                   active_low_q;

	logic                   accept;
	logic                   step;
	logic [COUNT_WIDTH-1:0] count_next;
	logic                   wrap;
	dither_stat_t           dstat;
	logic                   level;
	logic [OUT_DATA_W-1:0]  word;
	logic                   pop;

	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;
	logic                   skid_valid_q;
	logic [OUT_DATA_W-1:0]  skid_data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q                 <= PRESCALE_RST;
			period_q                   <= PERIOD_RST;
			dither_cfg_q.base_duty     <= '0;
			dither_cfg_q.extra_duty    <= '0;
			dither_cfg_q.dither_length <= DITHER_LENGTH_RST;
			active_low_q               <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESCALE:      prescale_q                 <= cfg_wdata;
				REG_PERIOD:        period_q                   <= cfg_wdata;
				REG_BASE_DUTY:     dither_cfg_q.base_duty     <= cfg_wdata;
				REG_EXTRA_DUTY:    dither_cfg_q.extra_duty    <= cfg_wdata;
				REG_DITHER_LENGTH: dither_cfg_q.dither_length <= cfg_wdata;
				REG_ACTIVE_LOW:    active_low_q               <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: room in the skid stage and no remainder folding under way.
	assign s_tready = !skid_valid_q && !dstat.busy;
	assign accept   = s_tvalid && s_tready;
	assign step     = accept && s_tdata[0];

	dpg_timebase #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_timebase (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.prescale   (prescale_q),
		.period     (period_q),
		.count_next (count_next),
		.wrap       (wrap)
	);

	dpg_dither u_dither (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (wrap),
		.cfg    (dither_cfg_q),
		.stat   (dstat)
	);

	// Result word from the state after this tick.
	always_comb begin
		level = (LVL_W'(count_next) < LVL_W'(dstat.compare_next)) ^ active_low_q;
		word  = {(OUT_DATA_W - COMPARE_W - 2)'(0), dstat.compare_next, wrap, level};
	end

	// Output register with a skid stage behind it.
	assign pop = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (accept) begin
				out_data_q <= word;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_data_q <= word;
			end else begin
				out_data_q <= word;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* src/dpg_modunit.sv */
// ----------------------------------------------------------------------------
// dpg_modunit: iterative remainder unit
// Restoring remainder of a 17-bit dividend by a 16-bit divisor, one
// quotient bit per cycle. Used only when the accumulator must be folded
// back below a freshly shortened dither length.
// ----------------------------------------------------------------------------
module dpg_modunit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [15:0] remainder
);
	import dpg_pkg::*;

	localparam int STEPS = 17;
	localparam int CNT_W = $clog2(STEPS);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [16:0]      rem_q;
	logic [16:0]      dvd_q;
	logic [15:0]      dvs_q;
	logic [16:0]      rem_sh;
	logic [16:0]      rem_d;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		rem_sh = {rem_q[15:0], dvd_q[16]};
		if (rem_sh >= {1'b0, dvs_q}) begin
			rem_d = rem_sh - {1'b0, dvs_q};
		end else begin
			rem_d = rem_sh;
		end
	end

	// Control and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			dvd_q <= {dvd_q[15:0], 1'b0};
		end
	end

	assign busy      = busy_q;
	assign done      = busy_q && (cnt_q == '0);
	assign remainder = rem_d[15:0];

endmodule

/* src/dpg_dither.sv */
// ----------------------------------------------------------------------------
// dpg_dither: first-order dither accumulator and compare loader
// At each period start the accumulator adds the saturated fraction modulo
// the dither length, and the compare becomes base_duty or base_duty + 1.
// ----------------------------------------------------------------------------
module dpg_dither (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  dpg_pkg::dither_cfg_t cfg,
	output dpg_pkg::dither_stat_t stat
);
	import dpg_pkg::*;

	logic [DUTY_W-1:0]    acc_q;
	logic [COMPARE_W-1:0] cmp_q;

	logic [DUTY_W-1:0]    len;
	logic [DUTY_W-1:0]    len_m1;
	logic [DUTY_W-1:0]    ext;
	logic [16:0]          sum;
	logic [16:0]          diff;
	logic                 carry;
	logic                 need_mod;
	logic [DUTY_W-1:0]    acc_new;
	logic [COMPARE_W-1:0] cmp_new;

	logic                 mod_busy;
	logic                 mod_done;
	logic [DUTY_W-1:0]    mod_rem;

	// Next accumulator and compare for a period start.
	always_comb begin
		len      = (cfg.dither_length == '0) ? DUTY_W'(1) : cfg.dither_length;
		len_m1   = len - 1'b1;
		ext      = (cfg.extra_duty > len_m1) ? len_m1 : cfg.extra_duty;
		sum      = {1'b0, acc_q} + {1'b0, ext};
		carry    = sum >= {1'b0, len};
		diff     = sum - {1'b0, len};
		need_mod = carry && (diff >= {1'b0, len});
		acc_new  = carry ? diff[DUTY_W-1:0] : sum[DUTY_W-1:0];
		cmp_new  = carry ? ({1'b0, cfg.base_duty} + 1'b1) : {1'b0, cfg.base_duty};
	end

	// The accumulator only lands above the length after the length is
	// lowered; the remainder unit then folds it back below the length.
	dpg_modunit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (load && need_mod),
		.dividend  (diff),
		.divisor   (len),
		.busy      (mod_busy),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// Accumulator and active compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cmp_q <= '0;
		end else if (load) begin
			acc_q <= acc_new;
			cmp_q <= cmp_new;
		end else if (mod_done) begin
			acc_q <= mod_rem;
		end
	end

	assign stat.busy         = mod_busy;
	assign stat.compare_next = load ? cmp_new : cmp_q;

endmodule

/* src/dpg_timebase.sv */
// ----------------------------------------------------------------------------
// dpg_timebase: prescaler and PWM period counter
// The prescaler counts ticks; each time it expires the period counter
// advances, and it wraps to zero on reaching or passing the period.
// ----------------------------------------------------------------------------
module dpg_timebase #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [15:0]            prescale,
	input  logic [15:0]            period,
	output logic [COUNT_WIDTH-1:0] count_next,
	output logic                   wrap
);
	import dpg_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	logic [COUNT_WIDTH-1:0] pre_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] pre_inc;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [15:0]            pre_lim;
	logic [15:0]            per_lim;
	logic                   pre_exp;
	logic                   cnt_exp;
	logic [COUNT_WIDTH-1:0] pre_next;

	// Expiry tests: reached or passed the limit, or wrapped round.
	always_comb begin
		pre_lim  = (prescale == '0) ? 16'd1 : prescale;
		per_lim  = (period == '0) ? 16'd1 : period;
		pre_inc  = pre_q + 1'b1;
		cnt_inc  = cnt_q + 1'b1;
		pre_exp  = (CMP_W'(pre_inc) >= CMP_W'(pre_lim)) || (pre_inc == '0);
		cnt_exp  = (CMP_W'(cnt_inc) >= CMP_W'(per_lim)) || (cnt_inc == '0);
		pre_next   = pre_q;
		count_next = cnt_q;
		wrap       = 1'b0;
		if (step) begin
			if (pre_exp) begin
				pre_next = '0;
				if (cnt_exp) begin
					count_next = '0;
					wrap       = 1'b1;
				end else begin
					count_next = cnt_inc;
				end
			end else begin
				pre_next = pre_inc;
			end
		end
	end

	// Counter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= '0;
			cnt_q <= '0;
		end else begin
			pre_q <= pre_next;
			cnt_q <= count_next;
		end
	end

endmodule

/* src/dpg_checker.sv */
// ----------------------------------------------------------------------------
// dpg_checker: port-level checks for the dithered PWM generator
// Watches the output stream and configuration ports and is bound to the top level.
// ----------------------------------------------------------------------------
module dpg_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_we,
	input logic [dpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input logic [dpg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [dpg_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import dpg_pkg::*;

	logic                 out_fire;
	logic [COMPARE_W-1:0] last_cmp_q;
	logic                 active_low_q;

	assign out_fire = m_tvalid && m_tready;

	// Compare of the last delivered word and the polarity last written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmp_q   <= '0;
			active_low_q <= 1'b0;
		end else begin
			if (out_fire) begin
				last_cmp_q <= m_tdata[COMPARE_W+1:2];
			end
			if (cfg_we && (cfg_index == REG_ACTIVE_LOW)) begin
				active_low_q <= cfg_wdata[0];
			end
		end
	end

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output word changed while stalled");

	// The compare only changes on a word that starts a period.
	a_cmp_period: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !m_tdata[1]) |-> (m_tdata[COMPARE_W+1:2] == last_cmp_q))
		else $error("compare changed without a period start");

	// With a zero compare the pin is inactive.
	a_zero_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && (m_tdata[COMPARE_W+1:2] == '0)) |-> (m_tdata[0] == active_low_q))
		else $error("pin active with a zero compare");

endmodule

bind dithered_pwm_generator dpg_checker u_dpg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_wdata (cfg_wdata),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
